// ===== hdl/ipml_pkg.sv =====
`timescale 1ns / 1ps

package ipml_pkg;

    // Controller sizing.
    localparam int MOTORS         = 4;
    localparam int GAIN_FRAC_BITS = 12;
    localparam int ACC_FRAC       = 12;
    localparam int SLOTS          = 2 * MOTORS;
    localparam int SLOT_W         = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Field and state widths.
    localparam int MOTOR_W  = 2;
    localparam int VALUE_W  = 16;
    localparam int GAIN_W   = 16;
    localparam int LIMIT_W  = 15;
    localparam int ERR_W    = VALUE_W + 1;
    localparam int DIFF_W   = ERR_W + 1;
    localparam int ACC_W    = 28;
    localparam int DRIVE_W  = 16;
    localparam int WORD_W   = ACC_W + ERR_W;

    // Datapath widths for the gain products and the accumulator update.
    localparam int PK_W     = GAIN_W + 1 + DIFF_W;
    localparam int IK_W     = GAIN_W + 1 + ERR_W;
    localparam int SUM_W    = PK_W + 1;
    localparam int SHL      = (GAIN_FRAC_BITS < ACC_FRAC) ? ACC_FRAC - GAIN_FRAC_BITS : 0;
    localparam int SHR      = (GAIN_FRAC_BITS > ACC_FRAC) ? GAIN_FRAC_BITS - ACC_FRAC : 0;
    localparam int SCL_W    = SUM_W + SHL;
    localparam int TOT_W    = ((SCL_W > ACC_W) ? SCL_W : ACC_W) + 1;

    // Stream and bus widths.
    localparam int S_DATA_W = ((MOTOR_W + 2 * VALUE_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((DRIVE_W + 7) / 8) * 8;
    localparam int ADDR_W   = 5;
    localparam int BUS_W    = 32;

    // Register map, one word each.
    typedef enum logic [2:0] {
        REG_SPEED_KP      = 3'd0,
        REG_SPEED_KI      = 3'd1,
        REG_SPEED_LIMIT   = 3'd2,
        REG_CURRENT_KP    = 3'd3,
        REG_CURRENT_KI    = 3'd4,
        REG_CURRENT_LIMIT = 3'd5
    } reg_idx_t;

    // Reset values of the registers.
    localparam logic [GAIN_W-1:0]  RST_SPEED_KP      = GAIN_W'(3277);
    localparam logic [GAIN_W-1:0]  RST_SPEED_KI      = GAIN_W'(2458);
    localparam logic [LIMIT_W-1:0] RST_SPEED_LIMIT   = LIMIT_W'(32767);
    localparam logic [GAIN_W-1:0]  RST_CURRENT_KP    = GAIN_W'(3891);
    localparam logic [GAIN_W-1:0]  RST_CURRENT_KI    = GAIN_W'(3891);
    localparam logic [LIMIT_W-1:0] RST_CURRENT_LIMIT = LIMIT_W'(1000);

    // Loop kind codes.
    localparam logic KIND_SPEED   = 1'b0;
    localparam logic KIND_CURRENT = 1'b1;

    // Register file contents as seen by the datapath.
    typedef struct packed {
        logic [GAIN_W-1:0]  speed_kp;
        logic [GAIN_W-1:0]  speed_ki;
        logic [LIMIT_W-1:0] speed_limit;
        logic [GAIN_W-1:0]  current_kp;
        logic [GAIN_W-1:0]  current_ki;
        logic [LIMIT_W-1:0] current_limit;
    } cfg_t;

endpackage

// ===== hdl/ipml_ram.sv =====
`timescale 1ns / 1ps

module ipml_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port; a read of the address
    // being written returns the old word.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/ipml_cfg.sv =====
`timescale 1ns / 1ps

module ipml_cfg
    import ipml_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [BUS_W-1:0]  pwdata,
    output logic [BUS_W-1:0]  prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign cfg    = cfg_reg;

    // Register write decode.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_SPEED_KP:      cfg_next.speed_kp      = pwdata[GAIN_W-1:0];
                REG_SPEED_KI:      cfg_next.speed_ki      = pwdata[GAIN_W-1:0];
                REG_SPEED_LIMIT:   cfg_next.speed_limit   = pwdata[LIMIT_W-1:0];
                REG_CURRENT_KP:    cfg_next.current_kp    = pwdata[GAIN_W-1:0];
                REG_CURRENT_KI:    cfg_next.current_ki    = pwdata[GAIN_W-1:0];
                REG_CURRENT_LIMIT: cfg_next.current_limit = pwdata[LIMIT_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.speed_kp      <= RST_SPEED_KP;
            cfg_reg.speed_ki      <= RST_SPEED_KI;
            cfg_reg.speed_limit   <= RST_SPEED_LIMIT;
            cfg_reg.current_kp    <= RST_CURRENT_KP;
            cfg_reg.current_ki    <= RST_CURRENT_KI;
            cfg_reg.current_limit <= RST_CURRENT_LIMIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read-back mux; unmapped addresses read as zero.
    always_comb
    begin
        unique case (idx)
            REG_SPEED_KP:      prdata = BUS_W'(cfg_reg.speed_kp);
            REG_SPEED_KI:      prdata = BUS_W'(cfg_reg.speed_ki);
            REG_SPEED_LIMIT:   prdata = BUS_W'(cfg_reg.speed_limit);
            REG_CURRENT_KP:    prdata = BUS_W'(cfg_reg.current_kp);
            REG_CURRENT_KI:    prdata = BUS_W'(cfg_reg.current_ki);
            REG_CURRENT_LIMIT: prdata = BUS_W'(cfg_reg.current_limit);
            default:           prdata = '0;
        endcase
    end

endmodule

// ===== hdl/ipml_core.sv =====
`timescale 1ns / 1ps

module ipml_core
    import ipml_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 in_kind,
    input  logic [MOTOR_W-1:0]   in_motor,
    input  logic [VALUE_W-1:0]   in_setpoint,
    input  logic [VALUE_W-1:0]   in_measured,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [DRIVE_W-1:0]   out_drive,
    output logic                 out_clamped
);

    // Handshake and stage movement.
    logic accept;
    logic out_free;
    logic s2_adv;
    logic s2_free;
    logic s1_adv;
    logic s1_free;
    logic wr_en;

    // Stage 1: state read in flight.
    logic                     s1_valid_reg, s1_valid_next;
    logic                     s1_kind_reg;
    logic [SLOT_W-1:0]        s1_slot_reg;
    logic                     s1_ok_reg;
    logic signed [ERR_W-1:0]  s1_err_reg;
    logic                     s1_filled_reg;

    // Stage 2: products ready, accumulator update.
    logic                     s2_valid_reg, s2_valid_next;
    logic                     s2_kind_reg;
    logic [SLOT_W-1:0]        s2_slot_reg;
    logic                     s2_ok_reg;
    logic signed [ERR_W-1:0]  s2_err_reg;
    logic signed [PK_W-1:0]   s2_pk_reg;
    logic signed [IK_W-1:0]   s2_ik_reg;
    logic signed [ACC_W-1:0]  s2_acc_reg;

    // Output register.
    logic                     out_valid_reg, out_valid_next;
    logic [DRIVE_W-1:0]       drive_reg;
    logic                     clamped_reg;

    // Last word written to the state memory, for forwarding.
    logic                     wb_valid_reg;
    logic [SLOT_W-1:0]        wb_slot_reg;
    logic signed [ERR_W-1:0]  wb_err_reg;
    logic signed [ACC_W-1:0]  wb_acc_reg;

    // Per-entry written flags; an unwritten entry reads as zero.
    logic [SLOTS-1:0]         filled_reg, filled_next;

    // Memory ports.
    logic [SLOT_W-1:0]        rd_slot;
    logic [WORD_W-1:0]        rdata;
    logic [WORD_W-1:0]        wdata;

    // Stage 1 datapath.
    logic signed [ERR_W-1:0]  in_err;
    logic                     in_ok;
    logic signed [ERR_W-1:0]  mem_err;
    logic signed [ACC_W-1:0]  mem_acc;
    logic signed [ERR_W-1:0]  last_err;
    logic signed [ACC_W-1:0]  acc_in;
    logic signed [DIFF_W-1:0] diff;
    logic [GAIN_W-1:0]        kp;
    logic [GAIN_W-1:0]        ki;
    logic signed [PK_W-1:0]   pk;
    logic signed [IK_W-1:0]   ik;

    // Stage 2 datapath.
    logic [LIMIT_W-1:0]       limit;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SCL_W-1:0]  scaled;
    logic signed [TOT_W-1:0]  acc_sum;
    logic signed [TOT_W-1:0]  lim_ext;
    logic signed [ACC_W-1:0]  acc_new;
    logic                     clamp_hit;
    logic signed [ACC_W-1:0]  drive_full;

    assign out_free = !out_valid_reg || out_ready;
    assign s2_adv   = s2_valid_reg && out_free;
    assign s2_free  = !s2_valid_reg || s2_adv;
    assign s1_adv   = s1_valid_reg && s2_free;
    assign s1_free  = !s1_valid_reg || s1_adv;
    assign in_ready = s1_free;
    assign accept   = in_valid && in_ready;
    assign wr_en    = s2_adv && s2_ok_reg;

    assign out_valid   = out_valid_reg;
    assign out_drive   = drive_reg;
    assign out_clamped = clamped_reg;

    // Slot address and error of the incoming beat.
    assign in_ok   = (int'(in_motor) < MOTORS);
    assign rd_slot = SLOT_W'(in_kind) * SLOT_W'(MOTORS) + SLOT_W'(in_motor);
    assign in_err  = ERR_W'($signed(in_setpoint)) - ERR_W'($signed(in_measured));

    assign wdata = {acc_new, s2_err_reg};

    ipml_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SLOTS)
    ) u_state_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s2_slot_reg),
        .wdata (wdata),
        .re    (accept),
        .raddr (rd_slot),
        .rdata (rdata)
    );

    // Stored state, zero where the entry was never written.
    always_comb
    begin
        if (s1_filled_reg)
        begin
            mem_err = $signed(rdata[ERR_W-1:0]);
            mem_acc = $signed(rdata[WORD_W-1:ERR_W]);
        end
        else
        begin
            mem_err = '0;
            mem_acc = '0;
        end
    end

    // Forwarding: the beat in stage 2 is newest, then the last write, then memory.
    always_comb
    begin
        if (s2_valid_reg && s2_ok_reg && (s2_slot_reg == s1_slot_reg))
        begin
            last_err = s2_err_reg;
            acc_in   = acc_new;
        end
        else if (wb_valid_reg && (wb_slot_reg == s1_slot_reg))
        begin
            last_err = wb_err_reg;
            acc_in   = wb_acc_reg;
        end
        else
        begin
            last_err = mem_err;
            acc_in   = mem_acc;
        end
    end

    // Gain products.
    assign kp   = (s1_kind_reg == KIND_CURRENT) ? cfg.current_kp : cfg.speed_kp;
    assign ki   = (s1_kind_reg == KIND_CURRENT) ? cfg.current_ki : cfg.speed_ki;
    assign diff = DIFF_W'(s1_err_reg) - DIFF_W'(last_err);
    assign pk   = $signed({1'b0, kp}) * diff;
    assign ik   = $signed({1'b0, ki}) * s1_err_reg;

    // Accumulator update, scaling to the accumulator format and clamp.
    assign limit   = (s2_kind_reg == KIND_CURRENT) ? cfg.current_limit : cfg.speed_limit;
    assign sum     = SUM_W'(s2_pk_reg) + SUM_W'(s2_ik_reg);
    assign scaled  = (SCL_W'(sum) <<< SHL) >>> SHR;
    assign acc_sum = TOT_W'(s2_acc_reg) + TOT_W'(scaled);
    assign lim_ext = $signed({{(TOT_W - LIMIT_W - ACC_FRAC){1'b0}}, limit,
                              {ACC_FRAC{1'b0}}});

    always_comb
    begin
        if (acc_sum > lim_ext)
        begin
            acc_new   = ACC_W'(lim_ext);
            clamp_hit = 1'b1;
        end
        else if (acc_sum < -lim_ext)
        begin
            acc_new   = ACC_W'(-lim_ext);
            clamp_hit = 1'b1;
        end
        else
        begin
            acc_new   = ACC_W'(acc_sum);
            clamp_hit = 1'b0;
        end
    end

    // Integer part truncated toward zero.
    assign drive_full = acc_new[ACC_W-1]
                      ? ((acc_new + ACC_W'((1 << ACC_FRAC) - 1)) >>> ACC_FRAC)
                      : (acc_new >>> ACC_FRAC);

    always_comb
    begin
        filled_next = filled_reg;
        if (wr_en)
        begin
            filled_next[s2_slot_reg] = 1'b1;
        end
    end

    assign s1_valid_next  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
    assign s2_valid_next  = s1_adv ? 1'b1 : (s2_adv ? 1'b0 : s2_valid_reg);
    assign out_valid_next = s2_adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            wb_valid_reg  <= 1'b0;
            filled_reg    <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
            filled_reg    <= filled_next;
            if (wr_en)
            begin
                wb_valid_reg <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg   <= in_kind;
            s1_slot_reg   <= rd_slot;
            s1_ok_reg     <= in_ok;
            s1_err_reg    <= in_err;
            s1_filled_reg <= filled_reg[rd_slot];
        end
        if (s1_adv)
        begin
            s2_kind_reg <= s1_kind_reg;
            s2_slot_reg <= s1_slot_reg;
            s2_ok_reg   <= s1_ok_reg;
            s2_err_reg  <= s1_err_reg;
            s2_pk_reg   <= pk;
            s2_ik_reg   <= ik;
            s2_acc_reg  <= acc_in;
        end
        if (s2_adv)
        begin
            drive_reg   <= s2_ok_reg ? DRIVE_W'(drive_full) : '0;
            clamped_reg <= s2_ok_reg && clamp_hit;
        end
        if (wr_en)
        begin
            wb_slot_reg <= s2_slot_reg;
            wb_err_reg  <= s2_err_reg;
            wb_acc_reg  <= acc_new;
        end
    end

endmodule

// ===== hdl/incremental_pi_motor_loops.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Handshake           Payload
// s_*       in   s_tvalid/s_tready   s_tuser: kind; s_tdata: motor, setpoint, measured
// m_*       out  m_tvalid/m_tready   m_tuser: clamped; m_tdata: drive
// APB       in   psel/penable        six registers at byte address 4*i
//
// One beat per cycle is accepted and one result per cycle is delivered as long as
// m_tready does not stall the output; a beat passes in order through the state
// memory read, the gain multiplier stage and the accumulator add and clamp stage.
// Back-to-back beats to the same motor are served by forwarding from the later
// stages, so there is no interlock bubble.
// Reset clears all controller state through per-entry written flags.
// A stall on m_tready holds only full stages; s_tready falls only when all three are full.

module incremental_pi_motor_loops
    import ipml_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // motor[1:0], setpoint[17:2], measured[33:18]
    input  logic                s_tuser,   // kind
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // drive[15:0]
    output logic                m_tuser,   // clamped
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [BUS_W-1:0]    pwdata,
    output logic [BUS_W-1:0]    prdata,
    output logic                pready
);

    cfg_t               cfg;
    logic [DRIVE_W-1:0] drive;

    ipml_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ipml_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_kind     (s_tuser),
        .in_motor    (s_tdata[MOTOR_W-1:0]),
        .in_setpoint (s_tdata[MOTOR_W+VALUE_W-1:MOTOR_W]),
        .in_measured (s_tdata[MOTOR_W+2*VALUE_W-1:MOTOR_W+VALUE_W]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_drive   (drive),
        .out_clamped (m_tuser)
    );

    assign m_tdata = M_DATA_W'(drive);

endmodule

// ===== hdl/ipml_checker.sv =====
`timescale 1ns / 1ps

module ipml_checker
    import ipml_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // A stalled result beat stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // Truncation toward zero of a clamped accumulator never yields the most negative code.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[DRIVE_W-1:0] != {1'b1, {(DRIVE_W-1){1'b0}}}))
        else $error("drive out of range");

    // With the output side draining, the pipeline never backs up to the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while output is free");

    // A result after an empty output comes from a beat that passed both stages without a stall.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 3))
        else $error("result without a matching input beat");

endmodule

bind incremental_pi_motor_loops ipml_checker u_ipml_checker (.*);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import ipml_pkg::*;

    // Clock and reset.
    logic clk;
    logic rst_n = 1'b0;

    // Sample stream toward the controller.
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;   // motor[1:0], setpoint[17:2], measured[33:18]
    logic                s_tuser  = 1'b0; // kind

    // Drive stream out of the controller.
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;   // drive[15:0]
    logic                m_tuser;   // clamped

    // Register bus.
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [BUS_W-1:0]  pwdata  = '0;
    logic [BUS_W-1:0]  prdata;
    logic              pready;

    incremental_pi_motor_loops uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // One expected controller output.
    typedef struct {
        logic signed [DRIVE_W-1:0] drive;
        logic                      clamped;
    } drive_result_t;

    drive_result_t pending_drives[$];

    // Shadow copy of the gain and limit registers.
    logic [GAIN_W-1:0]  gain_speed_kp;
    logic [GAIN_W-1:0]  gain_speed_ki;
    logic [LIMIT_W-1:0] clamp_speed;
    logic [GAIN_W-1:0]  gain_current_kp;
    logic [GAIN_W-1:0]  gain_current_ki;
    logic [LIMIT_W-1:0] clamp_current;

    // Shadow controller state, one entry per loop and motor.
    logic signed [ERR_W-1:0] prev_err [SLOTS];
    logic signed [ACC_W-1:0] acc_q12  [SLOTS];

    int mismatch_count = 0;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    bit hold_request   = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Velocity-form PI update for one sample; queues the drive it should produce.
    function automatic void pi_update(input logic kind, input logic [MOTOR_W-1:0] motor,
                                      input logic signed [VALUE_W-1:0] sp,
                                      input logic signed [VALUE_W-1:0] ms);
        int            slot;
        longint        gain_p;
        longint        gain_i;
        longint        bound;
        longint        err;
        longint        delta;
        longint        acc;
        drive_result_t res;
        slot   = int'(kind) * MOTORS + int'(motor);
        gain_p = (kind == KIND_CURRENT) ? gain_current_kp : gain_speed_kp;
        gain_i = (kind == KIND_CURRENT) ? gain_current_ki : gain_speed_ki;
        bound  = (kind == KIND_CURRENT) ? clamp_current : clamp_speed;
        bound  = bound << ACC_FRAC;
        err    = longint'(sp) - longint'(ms);
        delta  = gain_p * (err - longint'(prev_err[slot])) + gain_i * err;
        if (GAIN_FRAC_BITS > ACC_FRAC)
            delta = delta >>> (GAIN_FRAC_BITS - ACC_FRAC);
        else
            delta = delta <<< (ACC_FRAC - GAIN_FRAC_BITS);
        acc = longint'(acc_q12[slot]) + delta;
        res.clamped = 1'b0;
        if (acc > bound)
        begin
            acc = bound;
            res.clamped = 1'b1;
        end
        else if (acc < -bound)
        begin
            acc = -bound;
            res.clamped = 1'b1;
        end
        acc_q12[slot]  = ACC_W'(acc);
        prev_err[slot] = ERR_W'(err);
        // Integer part, truncated toward zero.
        if (acc >= 0)
            res.drive = DRIVE_W'(acc >>> ACC_FRAC);
        else
            res.drive = DRIVE_W'(-((-acc) >>> ACC_FRAC));
        pending_drives.push_back(res);
    endfunction

    // Compare every delivered beat with the oldest prediction; pace m_tready.
    always @(posedge clk)
    begin
        drive_result_t want;
        int            hold_left;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_drives.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected beat: drive %0d clamped %0b",
                             $signed(m_tdata), m_tuser);
            end
            else
            begin
                want = pending_drives.pop_front();
                if (m_tdata !== want.drive || m_tuser !== want.clamped)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("drive mismatch: expected %0d/%0b, got %0d/%0b",
                                 want.drive, want.clamped, $signed(m_tdata), m_tuser);
                end
            end
        end
        // A long hold-off lets the pipeline fill and push back on the input.
        if (hold_request)
        begin
            hold_left    = 120;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Register write: setup cycle, then access cycle; shadow copy follows.
    task automatic write_reg(input reg_idx_t idx, input logic [BUS_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SPEED_KP:      gain_speed_kp   = value[GAIN_W-1:0];
            REG_SPEED_KI:      gain_speed_ki   = value[GAIN_W-1:0];
            REG_SPEED_LIMIT:   clamp_speed     = value[LIMIT_W-1:0];
            REG_CURRENT_KP:    gain_current_kp = value[GAIN_W-1:0];
            REG_CURRENT_KI:    gain_current_ki = value[GAIN_W-1:0];
            REG_CURRENT_LIMIT: clamp_current   = value[LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    // Offer one sample beat, with random idle cycles ahead of it.
    task automatic send_sample(input logic kind, input logic [MOTOR_W-1:0] motor,
                               input logic [VALUE_W-1:0] sp, input logic [VALUE_W-1:0] ms);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= S_DATA_W'({ms, sp, motor});
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        pi_update(kind, motor, sp, ms);
    endtask

    // Stop sending and let every predicted drive come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_drives.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_all(input logic [BUS_W-1:0] skp, input logic [BUS_W-1:0] ski,
                             input logic [BUS_W-1:0] slim, input logic [BUS_W-1:0] ckp,
                             input logic [BUS_W-1:0] cki, input logic [BUS_W-1:0] clim);
        write_reg(REG_SPEED_KP, skp);
        write_reg(REG_SPEED_KI, ski);
        write_reg(REG_SPEED_LIMIT, slim);
        write_reg(REG_CURRENT_KP, ckp);
        write_reg(REG_CURRENT_KI, cki);
        write_reg(REG_CURRENT_LIMIT, clim);
    endtask

    // Draw a gain: mostly moderate, sometimes zero or full scale.
    function automatic logic [BUS_W-1:0] pick_gain();
        case ($urandom_range(7))
            0:       return 32'd0;
            1:       return 32'hFFFF;
            2:       return $urandom;
            default: return $urandom_range(8192);
        endcase
    endfunction

    // Draw a clamp magnitude, with zero and full scale among them.
    function automatic logic [BUS_W-1:0] pick_limit();
        case ($urandom_range(7))
            0:       return 32'd0;
            1:       return 32'h7FFF;
            2:       return $urandom_range(20);
            3:       return $urandom;
            default: return $urandom_range(3000);
        endcase
    endfunction

    // Sample values: mostly a motor tracking its target, plus noise and rails.
    task automatic send_random_sample();
        logic [VALUE_W-1:0] sp;
        logic [VALUE_W-1:0] ms;
        int                 pick;
        logic [VALUE_W-1:0] rails[4];
        rails = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
        pick  = $urandom_range(99);
        sp    = VALUE_W'($urandom);
        if (pick < 60)
            ms = sp - VALUE_W'($urandom_range(400)) + VALUE_W'(200);
        else if (pick < 85)
            ms = VALUE_W'($urandom);
        else
        begin
            sp = rails[$urandom_range(3)];
            ms = rails[$urandom_range(3)];
        end
        send_sample(1'($urandom_range(1)), MOTOR_W'($urandom_range(3)), sp, ms);
    endtask

    // Rails of the error with the reset gains, then full-scale ones, every loop and motor, sign of truncation.
    task automatic test_directed_extremes();
        send_sample(KIND_SPEED, 0, 16'h7FFF, 16'h8000);
        send_sample(KIND_SPEED, 0, 16'h8000, 16'h7FFF);
        send_sample(KIND_SPEED, 0, 16'h8000, 16'h7FFF);
        send_sample(KIND_CURRENT, 1, 16'h0000, 16'h0000);
        send_sample(KIND_CURRENT, 1, 16'h0001, 16'h0000);
        send_sample(KIND_CURRENT, 1, 16'hFFFF, 16'h0000);
        send_sample(KIND_CURRENT, 1, 16'hFFFF, 16'h0000);
        for (int k = 0; k < 2; k++)
            for (int m = 0; m < MOTORS; m++)
                send_sample(1'(k), MOTOR_W'(m), VALUE_W'(1000 * m - 1500),
                            VALUE_W'(-300 * k));
        wait_drained();
        // Full-scale gains and limits; upper bus bits must be dropped.
        write_all('1, '1, '1, '1, '1, '1);
        send_sample(KIND_SPEED, 3, 16'h7FFF, 16'h8000);
        send_sample(KIND_CURRENT, 3, 16'h8000, 16'h7FFF);
        send_sample(KIND_CURRENT, 3, 16'h7FFF, 16'h8000);
        send_sample(KIND_SPEED, 2, 16'h0003, 16'h0005);
        wait_drained();
    endtask

    // Zero limit pins the accumulator at zero; zero gains leave it still.
    task automatic test_limit_zero();
        write_all(32'd4096, 32'd100, 32'd0, 32'd0, 32'd0, 32'd0);
        send_sample(KIND_SPEED, 0, 16'd50, 16'd10);
        send_sample(KIND_SPEED, 0, 16'd50, 16'd10);
        send_sample(KIND_SPEED, 1, 16'd0, 16'd0);
        send_sample(KIND_CURRENT, 2, 16'h7FFF, 16'h8000);
        send_sample(KIND_CURRENT, 2, 16'd0, 16'd0);
        wait_drained();
    endtask

    // Receiver holds off while samples keep coming, then the sender waits it out.
    task automatic test_back_pressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_all(32'd3277, 32'd2458, 32'd32767, 32'd3891, 32'd3891, 32'd1000);
        hold_request = 1'b1;
        for (int n = 0; n < 40; n++)
            send_sample(1'(n % 2), MOTOR_W'((n / 2) % MOTORS), VALUE_W'(n * 37),
                        VALUE_W'(-n * 11));
        wait_drained();
        for (int n = 0; n < 8; n++)
            send_random_sample();
        wait_drained();
    endtask

    // Random sample streams under one idling pattern, reconfigured between bursts.
    task automatic test_random_stream(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int burst = 0; burst < 4; burst++)
        begin
            write_all(pick_gain(), pick_gain(), pick_limit(),
                      pick_gain(), pick_gain(), pick_limit());
            for (int n = 0; n < 108; n++)
                send_random_sample();
            wait_drained();
        end
    endtask

    initial
    begin
        gain_speed_kp   = RST_SPEED_KP;
        gain_speed_ki   = RST_SPEED_KI;
        clamp_speed     = RST_SPEED_LIMIT;
        gain_current_kp = RST_CURRENT_KP;
        gain_current_ki = RST_CURRENT_KI;
        clamp_current   = RST_CURRENT_LIMIT;
        for (int i = 0; i < SLOTS; i++)
        begin
            prev_err[i] = '0;
            acc_q12[i]  = '0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_extremes();
        test_limit_zero();
        test_back_pressure();
        test_random_stream(6, 58);
        test_random_stream(58, 6);
        test_random_stream(0, 0);

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && pending_drives.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/ipml_pkg.sv
hdl/ipml_ram.sv
hdl/ipml_cfg.sv
hdl/ipml_core.sv
hdl/incremental_pi_motor_loops.sv
hdl/ipml_checker.sv
test/testbench.sv
